### hw/rtl/cab_pkg.sv
package cab_pkg;

   localparam int ADDR_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int CMP_W = 14;
   localparam int SHEET_BPP_SHIFT = 2;

   localparam logic signed [12:0] TARGET_X_RESET = 13'sd0;
   localparam logic signed [12:0] TARGET_Y_RESET = 13'sd0;
   localparam logic [10:0] SOURCE_X_RESET = 11'd0;
   localparam logic [10:0] SOURCE_Y_RESET = 11'd0;
   localparam logic [11:0] SOURCE_WIDTH_RESET = 12'd1;
   localparam logic [11:0] SOURCE_HEIGHT_RESET = 12'd1;
   localparam logic [11:0] SCREEN_WIDTH_RESET = 12'd640;
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_X      = 3'd0,
      CSR_TARGET_Y      = 3'd1,
      CSR_SOURCE_X      = 3'd2,
      CSR_SOURCE_Y      = 3'd3,
      CSR_SOURCE_WIDTH  = 3'd4,
      CSR_SOURCE_HEIGHT = 3'd5,
      CSR_SCREEN_WIDTH  = 3'd6,
      CSR_SCREEN_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [12:0] target_x;
      logic signed [12:0] target_y;
      logic [10:0]        source_x;
      logic [10:0]        source_y;
      logic [11:0]        source_width;
      logic [11:0]        source_height;
      logic [11:0]        screen_width;
      logic [11:0]        screen_height;
   } cfg_type;

   typedef struct packed {
      logic        blend_enable;
      logic [10:0] pixel_col;
      logic [10:0] pixel_row;
      logic [7:0]  src_red;
      logic [7:0]  src_green;
      logic [7:0]  src_blue;
      logic [7:0]  src_alpha;
      logic [7:0]  dst_red;
      logic [7:0]  dst_green;
      logic [7:0]  dst_blue;
   } req_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] frame_address;
      logic [ADDR_W-1:0] sheet_address;
      logic [7:0]        out_red;
      logic [7:0]        out_green;
      logic [7:0]        out_blue;
   } rsp_type;

   // ((256 - a) * d + a * s) >> 8
   function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] s,
                                             input logic [7:0] d);
      logic [8:0]  inv_a;
      logic [16:0] acc;
      inv_a = 9'd256 - {1'b0, a};
      acc = 17'(inv_a * {9'd0, d}) + 17'({8'd0, a} * {8'd0, s});
      return acc[15:8];
   endfunction

endpackage

### hw/rtl/cab_csr.sv
module cab_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [cab_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cab_pkg::CSR_DATA_W-1:0]  csr_data,
   output cab_pkg::cfg_type                cfg
);
   import cab_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_X:      cfg_in.target_x = signed'(csr_data[12:0]);
            CSR_TARGET_Y:      cfg_in.target_y = signed'(csr_data[12:0]);
            CSR_SOURCE_X:      cfg_in.source_x = csr_data[10:0];
            CSR_SOURCE_Y:      cfg_in.source_y = csr_data[10:0];
            CSR_SOURCE_WIDTH:  cfg_in.source_width = csr_data[11:0];
            CSR_SOURCE_HEIGHT: cfg_in.source_height = csr_data[11:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width = csr_data[11:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[11:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_x <= TARGET_X_RESET;
         cfg_ff.target_y <= TARGET_Y_RESET;
         cfg_ff.source_x <= SOURCE_X_RESET;
         cfg_ff.source_y <= SOURCE_Y_RESET;
         cfg_ff.source_width <= SOURCE_WIDTH_RESET;
         cfg_ff.source_height <= SOURCE_HEIGHT_RESET;
         cfg_ff.screen_width <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/cab_datapath.sv
module cab_datapath #(
   parameter int MAX_DIM = 2048,
   parameter int BYTES_PER_PIXEL = 4
) (
   input  cab_pkg::cfg_type cfg,
   input  cab_pkg::req_type req,
   output cab_pkg::rsp_type rsp
);
   import cab_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int POS_W = $clog2(MAX_DIM);

   logic [DIM_W-1:0]        sw_c;
   logic [DIM_W-1:0]        sh_c;
   logic [DIM_W-1:0]        tw_c;
   logic [DIM_W-1:0]        th_c;
   logic signed [CMP_W-1:0] x_pos;
   logic signed [CMP_W-1:0] y_pos;
   logic                    visible;
   logic [11:0]             sheet_row;
   logic [ADDR_W-1:0]       sheet_lin;
   logic [ADDR_W-1:0]       frame_lin;
   logic [ADDR_W-1:0]       frame_addr;
   logic [7:0]              blend_red;
   logic [7:0]              blend_green;
   logic [7:0]              blend_blue;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [11:0] v);
      return (32'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(v);
   endfunction

   always_comb begin
      sw_c = clamp_dim(cfg.source_width);
      sh_c = clamp_dim(cfg.source_height);
      tw_c = clamp_dim(cfg.screen_width);
      th_c = clamp_dim(cfg.screen_height);

      x_pos = CMP_W'(cfg.target_x) + signed'(CMP_W'(req.pixel_col));
      y_pos = CMP_W'(cfg.target_y) + signed'(CMP_W'(req.pixel_row));

      visible = (CMP_W'(req.pixel_col) < CMP_W'(sw_c)) &&
                (CMP_W'(req.pixel_row) < CMP_W'(sh_c)) &&
                !x_pos[CMP_W-1] && (unsigned'(x_pos) < CMP_W'(tw_c)) &&
                !y_pos[CMP_W-1] && (unsigned'(y_pos) < CMP_W'(th_c));

      sheet_row = 12'(req.pixel_row) + 12'(cfg.source_y);
      sheet_lin = ADDR_W'(sheet_row) * ADDR_W'(sw_c) + ADDR_W'(req.pixel_col) +
                  ADDR_W'(cfg.source_x);

      frame_lin = ADDR_W'(y_pos[POS_W-1:0]) * ADDR_W'(tw_c) + ADDR_W'(x_pos[POS_W-1:0]);
      frame_addr = ADDR_W'(frame_lin * ADDR_W'(BYTES_PER_PIXEL));

      blend_red = blend_chan(req.src_alpha, req.src_red, req.dst_red);
      blend_green = blend_chan(req.src_alpha, req.src_green, req.dst_green);
      blend_blue = blend_chan(req.src_alpha, req.src_blue, req.dst_blue);

      rsp.sheet_address = sheet_lin << SHEET_BPP_SHIFT;
      rsp.frame_address = '0;
      rsp.write_enable = 1'b0;
      rsp.out_red = '0;
      rsp.out_green = '0;
      rsp.out_blue = '0;
      if (visible) begin
         rsp.frame_address = frame_addr;
         if (!req.blend_enable) begin
            rsp.write_enable = 1'b1;
            rsp.out_red = req.src_red;
            rsp.out_green = req.src_green;
            rsp.out_blue = req.src_blue;
         end else if (req.src_alpha != 8'd0) begin
            rsp.write_enable = 1'b1;
            rsp.out_red = blend_red;
            rsp.out_green = blend_green;
            rsp.out_blue = blend_blue;
         end
      end
   end

endmodule

### hw/rtl/clipped_alpha_blit_pixel.sv
// Channel   Direction  Ports                          Moves
// req       in         req_valid/req_ready/req_data   one sprite pixel per transfer
// rsp       out        rsp_valid/rsp_ready/rsp_data   one write request per transfer
// csr       in         csr_valid/csr_ready/csr_index  register write, csr_data payload
//
// A req transfer reaches rsp_valid through the input register, then clipping, address
// multiply and blend logic into the result register.
// Throughput is one pixel per cycle while rsp_ready stays high.
// A stalled rsp holds its register; req keeps flowing until both stages are full.
// Synchronous reset empties both stages and loads the register defaults.
module clipped_alpha_blit_pixel #(
   parameter int MAX_DIM = 2048,
   parameter int BYTES_PER_PIXEL = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cab_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cab_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cab_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cab_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cab_pkg::*;

   cfg_type cfg;
   req_type s1_data_ff;
   req_type s1_data_in;
   logic    s1_valid_ff;
   logic    s1_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type result;
   logic    out_free;
   logic    out_load;
   logic    s1_free;

   cab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cab_datapath #(
      .MAX_DIM         (MAX_DIM),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_datapath (
      .cfg (cfg),
      .req (s1_data_ff),
      .rsp (result)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      out_load = s1_valid_ff && out_free;
      s1_free = !s1_valid_ff || out_load;
      s1_valid_in = s1_free ? req_valid : s1_valid_ff;
      s1_data_in = (s1_free && req_valid) ? req_data : s1_data_ff;
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
      out_data_in = out_load ? result : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      out_data_ff <= out_data_in;
   end

   assign req_ready = s1_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;
   assign csr_ready = 1'b1;

endmodule

### hw/rtl/cab_checker.sv
module cab_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input cab_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input cab_pkg::rsp_type                rsp_data,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [cab_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [cab_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cab_pkg::*;

   logic [$bits(req_type)-1:0] req_bits;
   logic [CSR_INDEX_W+CSR_DATA_W:0] csr_bits;

   assign req_bits = req_data;
   assign csr_bits = {csr_valid, csr_index, csr_data};

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // every req transfer shows up at rsp after the input and result registers
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && ($countones(req_bits) >= 0) |-> ##2 rsp_valid)
      else $error("rsp missing after req transfer");

   // with the output draining, the input never stalls
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req stalled while rsp drains");

   // suppressed writes carry no color
   a_quiet_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |->
         rsp_data.out_red == 8'd0 && rsp_data.out_green == 8'd0 &&
         rsp_data.out_blue == 8'd0)
      else $error("color on suppressed write");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_bits[CSR_INDEX_W+CSR_DATA_W] |-> csr_ready)
      else $error("csr write refused");

endmodule

bind clipped_alpha_blit_pixel cab_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import cab_pkg::*;

   localparam int MAX_DIM = 2048;
   localparam int STALL_LIMIT = 1000;

   typedef struct packed {
      csr_index_type idx;
      logic [CSR_DATA_W-1:0] val;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   req_type pixel_queue[$];
   reg_write_type reg_queue[$];
   rsp_type expected_writes[$];
   cfg_type shadow;
   cfg_type plan;
   bit calm = 1'b0;
   int errors = 0;
   int stall_cycles = 0;

   clipped_alpha_blit_pixel dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] mix8(int a, int s, int d);
      return 8'(((256 - a) * d + a * s) >> 8);
   endfunction

   function automatic int clamp_dim(logic [11:0] v);
      return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   function automatic rsp_type predict_write(req_type p);
      rsp_type r;
      int sw, sh, tw, th, x, y, sheet;
      bit vis;
      sw = clamp_dim(shadow.source_width);
      sh = clamp_dim(shadow.source_height);
      tw = clamp_dim(shadow.screen_width);
      th = clamp_dim(shadow.screen_height);
      x = int'($signed(shadow.target_x)) + int'(p.pixel_col);
      y = int'($signed(shadow.target_y)) + int'(p.pixel_row);
      vis = int'(p.pixel_col) < sw && int'(p.pixel_row) < sh &&
            x >= 0 && x < tw && y >= 0 && y < th;
      sheet = ((int'(p.pixel_row) + int'(shadow.source_y)) * sw + int'(p.pixel_col)
               + int'(shadow.source_x)) * 4;
      r = '0;
      r.sheet_address = sheet[ADDR_W-1:0];
      if (vis) begin
         r.frame_address = 24'((y * tw + x) * 4);
         if (!p.blend_enable) begin
            r.write_enable = 1'b1;
            r.out_red = p.src_red;
            r.out_green = p.src_green;
            r.out_blue = p.src_blue;
         end else if (p.src_alpha != 8'd0) begin
            r.write_enable = 1'b1;
            r.out_red = mix8(p.src_alpha, p.src_red, p.dst_red);
            r.out_green = mix8(p.src_alpha, p.src_green, p.dst_green);
            r.out_blue = mix8(p.src_alpha, p.src_blue, p.dst_blue);
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [23:0] exp, logic [23:0] got);
      if (exp !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
         errors++;
      end
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
            req_valid <= 1'b1;
            req_data <= pixel_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      reg_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!csr_valid || csr_ready) begin
         if (reg_queue.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
            w = reg_queue.pop_front();
            csr_valid <= 1'b1;
            csr_index <= w.idx;
            csr_data <= w.val;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(99) >= 14);
   end

   // monitor: register shadow, prediction, result check
   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         shadow.target_x <= TARGET_X_RESET;
         shadow.target_y <= TARGET_Y_RESET;
         shadow.source_x <= SOURCE_X_RESET;
         shadow.source_y <= SOURCE_Y_RESET;
         shadow.source_width <= SOURCE_WIDTH_RESET;
         shadow.source_height <= SOURCE_HEIGHT_RESET;
         shadow.screen_width <= SCREEN_WIDTH_RESET;
         shadow.screen_height <= SCREEN_HEIGHT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_TARGET_X: shadow.target_x <= csr_data[12:0];
               CSR_TARGET_Y: shadow.target_y <= csr_data[12:0];
               CSR_SOURCE_X: shadow.source_x <= csr_data[10:0];
               CSR_SOURCE_Y: shadow.source_y <= csr_data[10:0];
               CSR_SOURCE_WIDTH: shadow.source_width <= csr_data[11:0];
               CSR_SOURCE_HEIGHT: shadow.source_height <= csr_data[11:0];
               CSR_SCREEN_WIDTH: shadow.screen_width <= csr_data[11:0];
               CSR_SCREEN_HEIGHT: shadow.screen_height <= csr_data[11:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_writes.push_back(predict_write(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected rsp transfer, actual %0h", $time, rsp_data);
               errors++;
            end else begin
               exp = expected_writes.pop_front();
               check_field("write_enable", exp.write_enable, rsp_data.write_enable);
               check_field("frame_address", exp.frame_address, rsp_data.frame_address);
               check_field("sheet_address", exp.sheet_address, rsp_data.sheet_address);
               check_field("out_red", exp.out_red, rsp_data.out_red);
               check_field("out_green", exp.out_green, rsp_data.out_green);
               check_field("out_blue", exp.out_blue, rsp_data.out_blue);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (reg_queue.size() != 0 || csr_valid || pixel_queue.size() != 0 || req_valid ||
             expected_writes.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_config(cfg_type c);
      reg_queue.push_back('{CSR_TARGET_X, 13'(c.target_x)});
      reg_queue.push_back('{CSR_TARGET_Y, 13'(c.target_y)});
      reg_queue.push_back('{CSR_SOURCE_X, 13'(c.source_x)});
      reg_queue.push_back('{CSR_SOURCE_Y, 13'(c.source_y)});
      reg_queue.push_back('{CSR_SOURCE_WIDTH, 13'(c.source_width)});
      reg_queue.push_back('{CSR_SOURCE_HEIGHT, 13'(c.source_height)});
      reg_queue.push_back('{CSR_SCREEN_WIDTH, 13'(c.screen_width)});
      reg_queue.push_back('{CSR_SCREEN_HEIGHT, 13'(c.screen_height)});
      plan = c;
      wait_idle();
   endtask

   function automatic cfg_type setup(int tx, int ty, int sx, int sy, int sw, int sh,
                                     int scw, int sch);
      cfg_type c;
      c.target_x = 13'(tx);
      c.target_y = 13'(ty);
      c.source_x = 11'(sx);
      c.source_y = 11'(sy);
      c.source_width = 12'(sw);
      c.source_height = 12'(sh);
      c.screen_width = 12'(scw);
      c.screen_height = 12'(sch);
      return c;
   endfunction

   function automatic req_type pix(bit blend, int col, int row, int sr, int sg, int sb,
                                   int sa, int dr, int dg, int db);
      req_type p;
      p.blend_enable = blend;
      p.pixel_col = 11'(col);
      p.pixel_row = 11'(row);
      p.src_red = 8'(sr);
      p.src_green = 8'(sg);
      p.src_blue = 8'(sb);
      p.src_alpha = 8'(sa);
      p.dst_red = 8'(dr);
      p.dst_green = 8'(dg);
      p.dst_blue = 8'(db);
      return p;
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 0;
      if (r < 10) return 4095;
      if (r < 15) return 2048;
      if (r < 20) return 1;
      if (r < 25) return $urandom_range(4095, 2049);
      if (r < 65) return $urandom_range(64, 1);
      return $urandom_range(2048, 1);
   endfunction

   function automatic int pick_offset();
      int r;
      r = $urandom_range(99);
      if (r < 5) return -4096;
      if (r < 10) return 4095;
      if (r < 20) return $urandom_range(8191) - 4096;
      return $urandom_range(700) - 100;
   endfunction

   function automatic int pick_sheet();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 0;
      if (r == 1) return 2047;
      return $urandom_range(2047);
   endfunction

   function automatic req_type make_pixel(cfg_type c);
      req_type p;
      int w, h;
      w = clamp_dim(c.source_width);
      h = clamp_dim(c.source_height);
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      p = req_type'({$urandom, $urandom, $urandom});
      if ($urandom_range(99) < 80) begin
         p.pixel_col = 11'($urandom_range(w - 1));
         p.pixel_row = 11'($urandom_range(h - 1));
      end
      case ($urandom_range(9))
         0: p.src_alpha = 8'd0;
         1: p.src_alpha = 8'd255;
         default: ;
      endcase
      return p;
   endfunction

   initial begin
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults after reset: only pixel (0,0) of a 1x1 sprite is visible
      plan = setup(0, 0, 0, 0, 1, 1, 640, 480);
      pixel_queue.push_back(pix(0, 0, 0, 8'h12, 8'h34, 8'h56, 8'h78, 1, 2, 3));
      pixel_queue.push_back(pix(0, 1, 0, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0));
      wait_idle();

      apply_config(setup(-3, 5, 10, 20, 16, 8, 640, 480));
      pixel_queue.push_back(pix(0, 0, 0, 255, 255, 255, 255, 0, 0, 0));
      pixel_queue.push_back(pix(0, 2, 0, 1, 2, 3, 4, 5, 6, 7));
      pixel_queue.push_back(pix(0, 3, 0, 1, 2, 3, 4, 5, 6, 7));
      pixel_queue.push_back(pix(0, 15, 7, 200, 100, 50, 0, 9, 9, 9));
      pixel_queue.push_back(pix(0, 16, 7, 200, 100, 50, 0, 9, 9, 9));
      pixel_queue.push_back(pix(0, 15, 8, 200, 100, 50, 0, 9, 9, 9));
      pixel_queue.push_back(pix(1, 4, 1, 255, 255, 255, 0, 10, 20, 30));
      pixel_queue.push_back(pix(1, 4, 1, 255, 255, 255, 255, 0, 0, 0));
      pixel_queue.push_back(pix(1, 5, 2, 0, 0, 0, 1, 255, 255, 255));
      pixel_queue.push_back(pix(1, 6, 3, 255, 0, 255, 128, 0, 255, 0));
      pixel_queue.push_back(pix(1, 7, 4, 0, 255, 0, 255, 255, 0, 255));
      pixel_queue.push_back(pix(1, 2047, 2047, 255, 255, 255, 255, 255, 255, 255));
      wait_idle();

      // extremes: oversized dimensions, far offsets, wrapping sheet address
      apply_config(setup(-4096, 4095, 2047, 2047, 4095, 4095, 4095, 4095));
      pixel_queue.push_back(pix(0, 2047, 2047, 1, 2, 3, 4, 5, 6, 7));
      pixel_queue.push_back(pix(1, 0, 0, 1, 2, 3, 4, 5, 6, 7));
      pixel_queue.push_back(pix(1, 1024, 1024, 1, 2, 3, 4, 5, 6, 7));
      wait_idle();

      apply_config(setup(0, 0, 0, 0, 2048, 2048, 2048, 2048));
      pixel_queue.push_back(pix(0, 2047, 2047, 170, 85, 240, 15, 1, 1, 1));
      pixel_queue.push_back(pix(1, 0, 0, 85, 170, 15, 240, 254, 127, 63));
      pixel_queue.push_back(pix(1, 2047, 0, 85, 170, 15, 255, 254, 127, 63));
      pixel_queue.push_back(pix(0, 0, 2047, 85, 170, 15, 0, 254, 127, 63));
      wait_idle();

      // zero dimensions hide every pixel
      apply_config(setup(0, 0, 5, 5, 0, 0, 640, 480));
      pixel_queue.push_back(pix(0, 0, 0, 1, 2, 3, 4, 5, 6, 7));
      wait_idle();
      apply_config(setup(0, 0, 5, 5, 8, 8, 0, 0));
      pixel_queue.push_back(pix(0, 0, 0, 1, 2, 3, 4, 5, 6, 7));
      wait_idle();

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 1) begin
            apply_config(setup(-8, -8, 3, 7, 48, 40, 320, 240));
         end else begin
            apply_config(setup(pick_offset(), pick_offset(), pick_sheet(), pick_sheet(),
                               pick_dim(), pick_dim(), pick_dim(), pick_dim()));
         end
         calm = (ph == 1);
         n = (ph == 1) ? 150 : 72;
         for (int i = 0; i < n / 2; i++) pixel_queue.push_back(make_pixel(plan));
         // in every third phase the sender holds off until every pending write has come back
         if (ph % 3 == 0) wait_idle();
         for (int i = n / 2; i < n; i++) pixel_queue.push_back(make_pixel(plan));
         wait_idle();
         calm = 1'b0;
      end

      repeat (10) @(negedge clock);
      if (errors == 0 && expected_writes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
